FILE: rtl/depth_grid_triangulator_macros.svh
// Assertion macros used by the depth grid triangulator RTL.
`ifndef DEPTH_GRID_TRIANGULATOR_MACROS_SVH
`define DEPTH_GRID_TRIANGULATOR_MACROS_SVH
`ifndef SYNTH
`define DGT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("depth_grid_triangulator: check failed");
`define DGT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("depth_grid_triangulator: check failed");
`else
`define DGT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define DGT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/dgt_pkg.sv
// Types, constants and a helper function of the depth grid triangulator.
package dgt_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    localparam int DEPTH_W  = 11;
    localparam int INDEX_W  = 20;
    localparam int CFG_W    = 11;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 64;

    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [1:0]         corner_t;
    typedef logic [1:0]         reg_index_t;

    localparam reg_index_t REG_FRAME_WIDTH     = 2'd0;
    localparam reg_index_t REG_MAX_DEPTH_RANGE = 2'd1;
    localparam reg_index_t REG_INVALID_DEPTH   = 2'd2;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH     = 11'd640;
    localparam logic [CFG_W-1:0] RESET_MAX_DEPTH_RANGE = 11'd5;
    localparam logic [CFG_W-1:0] RESET_INVALID_DEPTH   = 11'd2047;

    localparam corner_t CORNER_TL = 2'd0;
    localparam corner_t CORNER_TR = 2'd1;
    localparam corner_t CORNER_BL = 2'd2;
    localparam corner_t CORNER_BR = 2'd3;

    localparam logic [1:0] TRI_COUNT [16] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
        2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2
    };

    localparam corner_t TRI_CORNER [16][6] = '{
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TR, CORNER_BL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TR, CORNER_BR, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_BL, CORNER_BR, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TR, CORNER_BL, CORNER_BR, CORNER_TL, CORNER_TL, CORNER_TL},
        '{CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BL, CORNER_TR, CORNER_BR}
    };

    function automatic depth_t tri_spread(depth_t a, depth_t b, depth_t c);
        depth_t lo;
        depth_t hi;
        lo = a;
        hi = a;
        if (b < lo) lo = b;
        if (b > hi) hi = b;
        if (c < lo) lo = c;
        if (c > hi) hi = c;
        return hi - lo;
    endfunction

endpackage

FILE: rtl/depth_grid_triangulator.sv
// Top level of the depth grid triangulator: line buffer, quad classification and output.
// A pixel item is registered in the quad stage and its results in the output register.
// Throughput: one pixel item per cycle unless m_tready stalls; an item with two triangles
// holds the quad stage until both pass the single output register, one result per cycle.
// Reset: aresetn is synchronous and active low; it clears counters, pipeline control and
// the neighbor pixels and loads register defaults. The line buffer is not cleared.
`include "depth_grid_triangulator_macros.svh"

module depth_grid_triangulator #(
    parameter int MAX_WIDTH  = dgt_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = dgt_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dgt_pkg::APB_AW-1:0]    paddr,
    input  logic [dgt_pkg::APB_DW-1:0]    pwdata,
    output logic [dgt_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: depth_sample[10:0], zero fill.
    input  logic [dgt_pkg::S_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: frame_start.
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: vertex_a[19:0], vertex_b[39:20], vertex_c[59:40], zero fill.
    output logic [dgt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import dgt_pkg::*;

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] max_depth_range_reg;
    logic [CFG_W-1:0] invalid_depth_reg;
    reg_index_t       apb_index;
    logic             apb_write;

    assign pready    = 1'b1;
    assign apb_index = paddr[3:2];
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg     <= RESET_FRAME_WIDTH;
            max_depth_range_reg <= RESET_MAX_DEPTH_RANGE;
            invalid_depth_reg   <= RESET_INVALID_DEPTH;
        end else if (apb_write) begin
            unique case (apb_index)
                REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[CFG_W-1:0];
                REG_MAX_DEPTH_RANGE: max_depth_range_reg <= pwdata[CFG_W-1:0];
                REG_INVALID_DEPTH:   invalid_depth_reg   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (apb_index)
            REG_FRAME_WIDTH:     prdata = {{(APB_DW-CFG_W){1'b0}}, frame_width_reg};
            REG_MAX_DEPTH_RANGE: prdata = {{(APB_DW-CFG_W){1'b0}}, max_depth_range_reg};
            REG_INVALID_DEPTH:   prdata = {{(APB_DW-CFG_W){1'b0}}, invalid_depth_reg};
            default:             prdata = '0;
        endcase
    end

    logic [WW-1:0] width_eff;

    always_comb begin
        if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else if (frame_width_reg < 11'd2) begin
            width_eff = WW'(2);
        end else begin
            width_eff = WW'(frame_width_reg);
        end
    end

    // Input side: position of the incoming pixel and line buffer access.
    logic          s_accept;
    depth_t        s_depth;
    logic          s_frame_start;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [31:0]   row_product;

    assign s_accept      = s_tvalid && s_tready;
    assign s_depth       = s_tdata[DEPTH_W-1:0];
    assign s_frame_start = s_tuser[0];
    assign col_cur       = s_frame_start ? '0 : col_reg;
    assign row_cur       = s_frame_start ? '0 : row_reg;
    assign row_product   = 32'(row_cur) * 32'(width_eff);

    always_comb begin
        if ((32'(col_cur) + 32'd1) >= 32'(width_eff)) begin
            col_next = '0;
            if (32'(row_cur) < 32'(MAX_HEIGHT - 1)) begin
                row_next = RW'(32'(row_cur) + 32'd1);
            end else begin
                row_next = row_cur;
            end
        end else begin
            col_next = CW'(32'(col_cur) + 32'd1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    depth_t row_mem [MAX_WIDTH];
    depth_t above_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            above_reg        <= row_mem[col_cur];
            row_mem[col_cur] <= s_depth;
        end
    end

    // Quad stage.
    logic          s1_valid_reg;
    logic          s1_second_reg;
    depth_t        s1_depth_reg;
    index_t        s1_product_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_quad_ok_reg;
    depth_t        left_reg;
    depth_t        upper_left_reg;

    depth_t     corner_depth [4];
    index_t     corner_index [4];
    index_t     base_index;
    index_t     width_index;
    logic [3:0] quad_code;
    logic [1:0] tri_count;
    logic       emit0;
    logic       emit1;
    logic       use_second;
    logic       out_free;
    logic       send;
    logic       s1_done;
    logic       send_last;
    index_t     send_a;
    index_t     send_b;
    index_t     send_c;
    depth_t     spread0;
    depth_t     spread1;

    assign base_index  = s1_product_reg + INDEX_W'(s1_col_reg);
    assign width_index = INDEX_W'(width_eff);

    assign corner_depth[CORNER_TL] = upper_left_reg;
    assign corner_depth[CORNER_TR] = above_reg;
    assign corner_depth[CORNER_BL] = left_reg;
    assign corner_depth[CORNER_BR] = s1_depth_reg;
    assign corner_index[CORNER_BR] = base_index;
    assign corner_index[CORNER_BL] = base_index - INDEX_W'(1);
    assign corner_index[CORNER_TR] = base_index - width_index;
    assign corner_index[CORNER_TL] = base_index - width_index - INDEX_W'(1);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            quad_code[k] = (corner_depth[k] != invalid_depth_reg);
        end
    end

    assign tri_count = TRI_COUNT[quad_code];
    assign spread0 = tri_spread(corner_depth[TRI_CORNER[quad_code][0]],
                                corner_depth[TRI_CORNER[quad_code][1]],
                                corner_depth[TRI_CORNER[quad_code][2]]);
    assign spread1 = tri_spread(corner_depth[TRI_CORNER[quad_code][3]],
                                corner_depth[TRI_CORNER[quad_code][4]],
                                corner_depth[TRI_CORNER[quad_code][5]]);
    assign emit0 = s1_quad_ok_reg && (tri_count != 2'd0) && (spread0 <= max_depth_range_reg);
    assign emit1 = s1_quad_ok_reg && (tri_count == 2'd2) && (spread1 <= max_depth_range_reg);

    assign use_second = s1_second_reg || !emit0;
    assign send_last  = s1_second_reg || !(emit0 && emit1);
    assign send_a = corner_index[TRI_CORNER[quad_code][use_second ? 3 : 0]];
    assign send_b = corner_index[TRI_CORNER[quad_code][use_second ? 4 : 1]];
    assign send_c = corner_index[TRI_CORNER[quad_code][use_second ? 5 : 2]];

    assign out_free = !m_tvalid || m_tready;
    assign send     = s1_valid_reg && (s1_second_reg || emit0 || emit1) && out_free;
    assign s1_done  = s1_valid_reg && ((!s1_second_reg && !emit0 && !emit1) ||
                                       (send && send_last));
    assign s_tready = !s1_valid_reg || s1_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s1_second_reg  <= 1'b0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end else begin
            if (s1_done) begin
                left_reg       <= s1_depth_reg;
                upper_left_reg <= above_reg;
                s1_second_reg  <= 1'b0;
            end else if (send) begin
                s1_second_reg <= 1'b1;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_depth_reg   <= s_depth;
            s1_product_reg <= row_product[INDEX_W-1:0];
            s1_col_reg     <= col_cur;
            s1_quad_ok_reg <= (row_cur != '0) && (col_cur != '0);
        end
    end

    // Output register.
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (send) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (send) begin
            m_data_reg <= {{(M_DATA_W-3*INDEX_W){1'b0}}, send_c, send_b, send_a};
            m_last_reg <= send_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `DGT_ASSERT_SAME(a_second_needs_item, aclk, aresetn, s1_second_reg, s1_valid_reg)
    `DGT_ASSERT_SAME(a_second_only_full_quad, aclk, aresetn, s1_second_reg, quad_code == 4'hF)
    `DGT_ASSERT_SAME(a_accept_frees_stage, aclk, aresetn, s_accept && s1_valid_reg, s1_done)
    `DGT_ASSERT_NEXT(a_first_of_two_not_last, aclk, aresetn, send && !send_last, s1_second_reg)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench of the depth grid triangulator: pixel stream in, triangle stream out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dgt_pkg::*;

    localparam int          MAX_W       = DEFAULT_MAX_WIDTH;
    localparam int          MAX_H       = DEFAULT_MAX_HEIGHT;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    typedef struct {
        index_t va;
        index_t vb;
        index_t vc;
        logic   last;
    } triangle_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    logic [CFG_W-1:0] cfg_width   = RESET_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_range   = RESET_MAX_DEPTH_RANGE;
    logic [CFG_W-1:0] cfg_invalid = RESET_INVALID_DEPTH;

    depth_t      line_buf [MAX_W];
    depth_t      left_depth     = '0;
    depth_t      up_left_depth  = '0;
    int unsigned col_count      = 0;
    int unsigned row_count      = 0;

    triangle_t   pending_tris [$];
    triangle_t   oldest_tri;
    int unsigned failures       = 0;
    int unsigned cycle_count    = 0;
    int unsigned pixels_sent    = 0;
    bit          no_idle        = 1'b0;

    depth_grid_triangulator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < MAX_W; i++) line_buf[i] = '0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tris.size() == 0) begin
                $error("unexpected triangle: vertex_a %0d vertex_b %0d vertex_c %0d",
                       m_tdata[19:0], m_tdata[39:20], m_tdata[59:40]);
                failures++;
            end else begin
                oldest_tri = pending_tris.pop_front();
                if (m_tdata[19:0] !== oldest_tri.va) begin
                    $error("vertex_a: expected %0d, got %0d", oldest_tri.va, m_tdata[19:0]);
                    failures++;
                end
                if (m_tdata[39:20] !== oldest_tri.vb) begin
                    $error("vertex_b: expected %0d, got %0d", oldest_tri.vb, m_tdata[39:20]);
                    failures++;
                end
                if (m_tdata[59:40] !== oldest_tri.vc) begin
                    $error("vertex_c: expected %0d, got %0d", oldest_tri.vc, m_tdata[59:40]);
                    failures++;
                end
                if (m_tlast !== oldest_tri.last) begin
                    $error("last_of_quad: expected %0d, got %0d", oldest_tri.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    function automatic int unsigned eff_width();
        if (cfg_width < 2) return 2;
        if (cfg_width > MAX_W) return MAX_W;
        return 32'(cfg_width);
    endfunction

    function automatic void predict_triangles(input depth_t depth, input logic frame_start);
        int unsigned w;
        int unsigned col;
        int unsigned row;
        depth_t      lo;
        depth_t      hi;
        int          k;
        int          j;
        int          t;
        int          ncand;
        int          nc;
        index_t      base;
        index_t      tl;
        depth_t      above;
        depth_t      cd [4];
        index_t      ci [4];
        logic [3:0]  valid;
        corner_t     cand [6];
        triangle_t   found [$];
        triangle_t   one_tri;
        w = eff_width();
        if (frame_start) begin
            col_count = 0;
            row_count = 0;
        end
        col = col_count;
        row = row_count;
        base = index_t'(row * w + col);
        above = line_buf[col];
        if (row > 0 && col > 0) begin
            tl = index_t'(base - w - 1);
            cd[CORNER_TL] = up_left_depth;
            ci[CORNER_TL] = tl;
            cd[CORNER_TR] = above;
            ci[CORNER_TR] = index_t'(tl + 1);
            cd[CORNER_BL] = left_depth;
            ci[CORNER_BL] = index_t'(tl + w);
            cd[CORNER_BR] = depth;
            ci[CORNER_BR] = index_t'(tl + w + 1);
            for (k = 0; k < 4; k++) valid[k] = (cd[k] != cfg_invalid);
            ncand = 0;
            if (&valid) begin
                cand = '{CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BL, CORNER_TR, CORNER_BR};
                ncand = 2;
            end else if ($countones(valid) == 3) begin
                nc = 0;
                for (k = 0; k < 4; k++) begin
                    if (valid[k]) begin
                        cand[nc] = corner_t'(k);
                        nc++;
                    end
                end
                ncand = 1;
            end
            for (t = 0; t < ncand; t++) begin
                lo = cd[cand[3*t]];
                hi = lo;
                for (j = 1; j < 3; j++) begin
                    if (cd[cand[3*t+j]] < lo) lo = cd[cand[3*t+j]];
                    if (cd[cand[3*t+j]] > hi) hi = cd[cand[3*t+j]];
                end
                if (hi - lo <= cfg_range) begin
                    one_tri.va = ci[cand[3*t]];
                    one_tri.vb = ci[cand[3*t+1]];
                    one_tri.vc = ci[cand[3*t+2]];
                    one_tri.last = 1'b0;
                    found.push_back(one_tri);
                end
            end
            if (found.size() > 0) found[found.size()-1].last = 1'b1;
            foreach (found[i]) pending_tris.push_back(found[i]);
        end
        up_left_depth = above;
        line_buf[col] = depth;
        left_depth = depth;
        if (col + 1 >= w) begin
            col_count = 0;
            if (row < MAX_H - 1) row_count = row + 1;
        end else begin
            col_count = col + 1;
        end
    endfunction

    function automatic depth_t pick_depth(input depth_t base);
        case ($urandom_range(0, 15))
            0, 1:    return cfg_invalid;
            2:       return depth_t'($urandom);
            3:       return $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            default: return depth_t'(base + $urandom_range(0, 7));
        endcase
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW-CFG_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:     cfg_width   = value;
            REG_MAX_DEPTH_RANGE: cfg_range   = value;
            REG_INVALID_DEPTH:   cfg_invalid = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] depth_range,
                             input logic [CFG_W-1:0] invalid_code);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_MAX_DEPTH_RANGE, depth_range);
        write_reg(REG_INVALID_DEPTH, invalid_code);
    endtask

    task automatic send_pixel(input depth_t depth, input logic frame_start);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-DEPTH_W){1'b0}}, depth};
        s_tuser  <= frame_start;
        do @(posedge aclk); while (!s_tready);
        predict_triangles(depth, frame_start);
        pixels_sent++;
    endtask

    task automatic send_frame(input int count, input bit head_start, input bit noisy);
        depth_t base;
        logic   fs;
        int     i;
        base = depth_t'($urandom_range(0, 2040));
        for (i = 0; i < count; i++) begin
            fs = (i == 0) && head_start;
            if (noisy && i == 0 && $urandom_range(0, 7) == 0) fs = 1'b0;
            if (noisy && i > 0 && $urandom_range(0, 59) == 0) fs = 1'b1;
            send_pixel(pick_depth(base), fs);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_case_table();
        depth_t pix [$];
        int     i;
        pix = '{100, 102, 2047, 101, 103, 104, 2047, 105, 2047, 0, 2047, 106,
                100, 104, 107, 1000, 10, 15, 10, 15, 10, 4};
        configure(3, 5, 2047);
        for (i = 0; i < pix.size(); i++) send_pixel(pix[i], i == 0 || i == 16);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        configure(0, 0, 0);
        send_frame(8, 1'b1, 1'b0);
        wait_idle();
        configure(1, 2047, 0);
        send_frame(8, 1'b1, 1'b0);
        wait_idle();
        configure(4, 2047, 2047);
        send_frame(14, 1'b1, 1'b0);
        wait_idle();
        configure(5, 0, 1000);
        send_frame(17, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_width_shrink();
        configure(6, 7, 2047);
        send_frame(9, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 2);
        send_frame(6, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_wide_rows();
        configure(2047, 5, 2047);
        send_frame(MAX_W + 5, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int          w;
        int          frames;
        int          f;
        int          count;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] depth_range;
        logic [CFG_W-1:0] invalid_code;
        start = pixels_sent;
        while (pixels_sent - start < 100) begin
            if (pixels_sent - start >= 60) no_idle = 1'b1;
            width = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 1)) :
                                                  CFG_W'($urandom_range(2, 12));
            case ($urandom_range(0, 5))
                0:       depth_range = 0;
                1:       depth_range = 2047;
                2:       depth_range = CFG_W'($urandom_range(0, 2047));
                default: depth_range = CFG_W'($urandom_range(0, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       invalid_code = CFG_W'($urandom_range(0, 2047));
                1:       invalid_code = 0;
                default: invalid_code = 2047;
            endcase
            configure(width, depth_range, invalid_code);
            w = eff_width();
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                count = w * $urandom_range(2, 6);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w - 1);
                send_frame(count, 1'b1, f > 0);
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_case_table();
        test_register_extremes();
        test_width_shrink();
        test_wide_rows();
        test_random_frames();
        wait_idle();
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dgt_pkg.sv
rtl/depth_grid_triangulator.sv
sim/testbench.sv
